/* rtl/pcrb_pkg.sv */
`default_nettype none

package pcrb_pkg;

  localparam int GpioPadsDef  = 30;
  localparam int FlashPadsDef = 6;

  localparam logic [11:0] OffSel       = 12'h000;
  localparam logic [11:0] OffClock     = 12'h07c;
  localparam logic [11:0] OffData      = 12'h080;
  localparam logic [11:0] OffGpioLast  = 12'h078;
  localparam logic [11:0] OffFlashLast = 12'h018;

  localparam logic [7:0] RstPad      = 8'h56;
  localparam logic [7:0] RstClkData  = 8'h5a;
  localparam logic [7:0] RstFlashMid = 8'h52;
  localparam logic [7:0] RstFlashEnd = 8'h5a;

  typedef enum logic [1:0] {
    ALIAS_PLAIN = 2'd0,
    ALIAS_XOR   = 2'd1,
    ALIAS_SET   = 2'd2,
    ALIAS_CLR   = 2'd3
  } alias_t;

  typedef struct packed {
    logic        mode;
    logic        bank;
    logic [11:0] offset;
    logic [1:0]  alias_req;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       unmapped;
  } out_word_t;

  function automatic logic [7:0] combine(input logic [7:0] prev, input logic [7:0] data,
                                         input logic [1:0] code);
    logic [7:0] res;
    res = data;
    case (alias_t'(code))
      ALIAS_XOR: res = prev ^ data;
      ALIAS_SET: res = prev | data;
      ALIAS_CLR: res = prev & ~data;
      default:   res = data;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/pad_control_register_banks_top.sv */
`default_nettype none

// Two pad-control register banks (gpio and flash interface) reached through one word
// channel. Each input word is a read or a write of one register; writes may use the xor,
// set or clear alias to modify the old value. Exactly one result word comes back per input
// word, in order: the stored value on a mapped read, zero on a write, plus an unmapped flag.
// One word is taken every cycle while the output moves; a taken word passes through the input
// register, then the result register, which is loaded as the single read-modify-write is
// done. With the output stalled, the input stalls once both registers are full.
module pad_control_register_banks_top #(
  parameter int GPIO_PADS  = pcrb_pkg::GpioPadsDef,
  parameter int FLASH_PADS = pcrb_pkg::FlashPadsDef
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pcrb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output pcrb_pkg::out_word_t out_data
);
  import pcrb_pkg::*;

  localparam int GW = (GPIO_PADS > 1) ? $clog2(GPIO_PADS) : 1;
  localparam int FW = (FLASH_PADS > 1) ? $clog2(FLASH_PADS) : 1;

  logic      s1_vld_r;
  in_word_t  s1_r;
  logic      out_vld_r;
  out_word_t out_r;

  logic       gpio_sel_r;
  logic       flash_sel_r;
  logic [7:0] clk_pad_r;
  logic [7:0] data_pad_r;
  logic [7:0] gpio_pad_r  [GPIO_PADS];
  logic [7:0] flash_pad_r [FLASH_PADS];

  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // address decode
  logic [9:0]    widx;
  logic [GW-1:0] g_idx;
  logic [FW-1:0] f_idx;
  logic          aligned;
  logic          hit_sel, hit_clk, hit_data, hit_gpio, hit_flash, mapped;
  logic          wr;
  logic [7:0]    cur;
  logic [7:0]    upd;

  always_comb begin
    widx      = s1_r.offset[11:2] - 10'd1;
    g_idx     = widx[GW-1:0];
    f_idx     = widx[FW-1:0];
    aligned   = (s1_r.offset[1:0] == 2'b00) && (s1_r.offset != OffSel);
    hit_sel   = (s1_r.offset == OffSel);
    hit_clk   = !s1_r.bank && (s1_r.offset == OffClock);
    hit_data  = !s1_r.bank && (s1_r.offset == OffData);
    hit_gpio  = !s1_r.bank && aligned && (s1_r.offset <= OffGpioLast)
                && (widx < 10'(GPIO_PADS));
    hit_flash = s1_r.bank && aligned && (s1_r.offset <= OffFlashLast)
                && (widx < 10'(FLASH_PADS));
    mapped    = hit_sel || hit_clk || hit_data || hit_gpio || hit_flash;
    wr        = s1_adv && s1_r.mode && mapped;

    cur = 8'h00;
    if (hit_sel)        cur = {7'd0, s1_r.bank ? flash_sel_r : gpio_sel_r};
    else if (hit_clk)   cur = clk_pad_r;
    else if (hit_data)  cur = data_pad_r;
    else if (hit_gpio)  cur = gpio_pad_r[g_idx];
    else if (hit_flash) cur = flash_pad_r[f_idx];

    upd = combine(cur, s1_r.write_data[7:0], s1_r.alias_req);
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc)        s1_vld_r <= 1'b1;
      else if (s1_adv)   s1_vld_r <= 1'b0;
      if (s1_adv)        out_vld_r <= 1'b1;
      else if (out_free) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= in_data;
    if (s1_adv) begin
      out_r.read_data <= (s1_r.mode || !mapped) ? 8'h00 : cur;
      out_r.unmapped  <= !mapped;
    end
  end

  // register banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpio_sel_r  <= 1'b0;
      flash_sel_r <= 1'b0;
      clk_pad_r   <= RstClkData;
      data_pad_r  <= RstClkData;
      for (int i = 0; i < GPIO_PADS; i++) gpio_pad_r[i] <= RstPad;
      for (int i = 0; i < FLASH_PADS; i++) begin
        if (i == 0)                   flash_pad_r[i] <= RstPad;
        else if (i == FLASH_PADS - 1) flash_pad_r[i] <= RstFlashEnd;
        else                          flash_pad_r[i] <= RstFlashMid;
      end
    end else if (wr) begin
      if (hit_sel && !s1_r.bank) gpio_sel_r  <= upd[0];
      if (hit_sel && s1_r.bank)  flash_sel_r <= upd[0];
      if (hit_clk)               clk_pad_r   <= upd;
      if (hit_data)              data_pad_r  <= upd;
      if (hit_gpio)              gpio_pad_r[g_idx]  <= upd;
      if (hit_flash)             flash_pad_r[f_idx] <= upd;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.unmapped |-> out_r.read_data == 8'h00)
    else $error("unmapped result carries data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced word lost before output");

endmodule

`default_nettype wire
